// File: sv/filmic_tonemap_pixel_top_macros.svh
// Assertion macros for the filmic tone-map block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef FILMIC_TONEMAP_PIXEL_TOP_MACROS_SVH
`define FILMIC_TONEMAP_PIXEL_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FTM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define FTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ftm_pkg.sv
// Shared types, widths and curve constants for the filmic tone-map block.
// No dependencies.
package ftm_pkg;

	localparam int XW = 24;            // input channel width
	localparam int OW = 17;            // output channel width
	localparam int TB = OW + 1;        // quotient bits kept before rounding
	localparam int IN_FRAC_DEF = 16;
	localparam int OUT_FRAC_DEF = 16;

	// Widths of the curve terms (input fraction bits must never exceed XW; the block does not enforce this)
	localparam int PW = 2 * XW + 10;
	localparam int QW = 2 * XW + 7;
	localparam int NUMW = PW + 13;
	localparam int DENW = QW + 17;

	// Exact rational form of the curve, scaled by the white point
	localparam int unsigned K_P2 = 420;
	localparam int unsigned K_P1 = 25;
	localparam int unsigned K_Q2 = 30;
	localparam int unsigned K_Q1 = 50;
	localparam int unsigned K_Q0 = 3;
	localparam int unsigned K_NUM = 6119;
	localparam int unsigned K_DEN = 66556;

	typedef logic [XW-1:0] chan_in_t;
	typedef logic [OW-1:0] chan_out_t;

	// Divider result for one lane
	typedef struct packed {
		logic          sat;
		logic [TB-1:0] quo;
	} div_res_t;

	// Round half up from the doubled quotient, saturate to the field range
	function automatic chan_out_t round_sat(input div_res_t r);
		logic [TB:0] inc;
		inc = {1'b0, r.quo} + (TB+1)'(1);
		if (r.sat || (&r.quo))
			return {OW{1'b1}};
		return inc[OW:1];
	endfunction

endpackage

// File: sv/ftm_pix_if.sv
// Pixel stream interfaces (valid/ready) for the filmic tone-map block.
// Depends on ftm_pkg.
interface ftm_in_if;
	logic               valid;
	logic               ready;
	ftm_pkg::chan_in_t  red_in;
	ftm_pkg::chan_in_t  green_in;
	ftm_pkg::chan_in_t  blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface ftm_out_if;
	logic               valid;
	logic               ready;
	ftm_pkg::chan_out_t red_out;
	ftm_pkg::chan_out_t green_out;
	ftm_pkg::chan_out_t blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: sv/ftm_lane.sv
// One channel lane: builds the curve numerator and denominator in three stages.
// Depends on ftm_pkg.
module ftm_lane #(
	parameter int IN_FRAC_BITS = ftm_pkg::IN_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  ftm_pkg::chan_in_t        x,
	output logic [ftm_pkg::NUMW-1:0] num,
	output logic [ftm_pkg::DENW-1:0] den
);
	localparam int XW = ftm_pkg::XW;
	localparam int PW = ftm_pkg::PW;
	localparam int QW = ftm_pkg::QW;
	localparam int NUMW = ftm_pkg::NUMW;
	localparam int DENW = ftm_pkg::DENW;

	logic [XW-1:0]   x_s1;
	logic [2*XW-1:0] xx_s1;
	logic [PW-1:0]   p_s2;
	logic [QW-1:0]   q_s2;
	logic [NUMW-1:0] num_s3;
	logic [DENW-1:0] den_s3;

	// Square the input
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x;
			xx_s1 <= (2*XW)'(x) * (2*XW)'(x);
		end
	end

	// Quadratic terms, constant multiplies and shifts only
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PW'(xx_s1) * PW'(ftm_pkg::K_P2)
				+ (PW'(x_s1) << IN_FRAC_BITS) * PW'(ftm_pkg::K_P1);
			q_s2 <= QW'(xx_s1) * QW'(ftm_pkg::K_Q2)
				+ (QW'(x_s1) << IN_FRAC_BITS) * QW'(ftm_pkg::K_Q1)
				+ (QW'(ftm_pkg::K_Q0) << (2 * IN_FRAC_BITS));
		end
	end

	// Apply the white-point scale factors
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= NUMW'(p_s2) * NUMW'(ftm_pkg::K_NUM);
			den_s3 <= DENW'(q_s2) * DENW'(ftm_pkg::K_DEN);
		end
	end

	assign num = num_s3;
	assign den = den_s3;

endmodule

// File: sv/ftm_div.sv
// Pipelined restoring divider: one quotient bit per stage, plus range check.
// Depends on ftm_pkg.
module ftm_div #(
	parameter int OUT_FRAC_BITS = ftm_pkg::OUT_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ftm_pkg::NUMW-1:0] num,
	input  logic [ftm_pkg::DENW-1:0] den,
	output ftm_pkg::div_res_t        res
);
	localparam int TB = ftm_pkg::TB;
	localparam int DENW = ftm_pkg::DENW;
	localparam int N2W = ftm_pkg::NUMW + OUT_FRAC_BITS + 1;
	localparam int W = (N2W > DENW + TB) ? N2W : DENW + TB;

	logic [W-1:0]    rem_s [0:TB];
	logic [DENW-1:0] d_s   [0:TB];
	logic [TB-1:0]   quo_s [0:TB];
	logic            sat_s [0:TB];

	logic [W-1:0] n2;
	logic [W-1:0] dtop;

	// Doubled, output-scaled numerator; flag quotients beyond the kept bits
	assign n2   = W'(num) << (OUT_FRAC_BITS + 1);
	assign dtop = W'(den) << TB;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n2;
			d_s[0]   <= den;
			quo_s[0] <= '0;
			sat_s[0] <= (n2 >= dtop);
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 1; k <= TB; k++) begin : g_step
		localparam int B = TB - k;
		logic [W-1:0] dsh;
		logic         ge;
		assign dsh = W'(d_s[k-1]) << B;
		assign ge  = (rem_s[k-1] >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (rem_s[k-1] - dsh) : rem_s[k-1];
				d_s[k]   <= d_s[k-1];
				quo_s[k] <= quo_s[k-1] | (ge ? (TB'(1) << B) : '0);
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign res.sat = sat_s[TB];
	assign res.quo = quo_s[TB];

endmodule

// File: sv/filmic_tonemap_pixel_top.sv
// Filmic tone-map pixel pipeline: three channel lanes, dividers, merge stage.
// Depends on ftm_pkg, ftm_pix_if, ftm_lane, ftm_div and the macro header.
//
// Usage:
//  pix_in carries one linear RGB pixel per transaction (Q8.16 by default);
//  pix_out returns the tone-mapped pixel (Q1.16 by default), one per input,
//  in order. Both are valid/ready channels.
//  Throughput: one pixel per cycle while pix_out is not stalled. Three
//  lanes run side by side, each a 3-stage curve unit followed by a
//  19-stage divider (a range-check stage, then one quotient bit a
//  stage), and one merge stage rounds and registers all three channels.
//  Reset: arst_n clears every stage valid bit; the pipeline comes up empty
//  and ready.
//  Stall: when pix_out holds a result that is not taken, the whole pipeline
//  freezes and pix_in.ready drops; pix_in.ready is high whenever the output
//  register is empty or being taken, so a stage never stalls on its own.
`include "filmic_tonemap_pixel_top_macros.svh"

module filmic_tonemap_pixel_top #(
	parameter int IN_FRAC_BITS = ftm_pkg::IN_FRAC_DEF,
	parameter int OUT_FRAC_BITS = ftm_pkg::OUT_FRAC_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ftm_in_if.sink   pix_in,
	ftm_out_if.source pix_out
);
	localparam int LAT = ftm_pkg::TB + 5;
	localparam int NL = 3;

	logic                     en;
	logic [LAT-1:0]           vld_s;
	ftm_pkg::chan_in_t        lane_x   [NL];
	logic [ftm_pkg::NUMW-1:0] lane_num [NL];
	logic [ftm_pkg::DENW-1:0] lane_den [NL];
	ftm_pkg::div_res_t        lane_res [NL];
	ftm_pkg::chan_out_t       out_q    [NL];

	// Advance everything unless the output holds a result nobody takes
	assign en = !vld_s[LAT-1] || pix_out.ready;
	assign pix_in.ready = en;

	// Track which stages hold a transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], pix_in.valid};
		end
	end

	assign lane_x[0] = pix_in.red_in;
	assign lane_x[1] = pix_in.green_in;
	assign lane_x[2] = pix_in.blue_in;

	// One curve unit and one divider per channel
	for (genvar i = 0; i < NL; i++) begin : g_lane
		ftm_lane #(
			.IN_FRAC_BITS(IN_FRAC_BITS)
		) u_lane (
			.clk(clk),
			.en (en),
			.x  (lane_x[i]),
			.num(lane_num[i]),
			.den(lane_den[i])
		);

		ftm_div #(
			.OUT_FRAC_BITS(OUT_FRAC_BITS)
		) u_div (
			.clk(clk),
			.en (en),
			.num(lane_num[i]),
			.den(lane_den[i]),
			.res(lane_res[i])
		);

		// Merge: round and saturate each lane into the output register
		always_ff @(posedge clk) begin
			if (en) begin
				out_q[i] <= ftm_pkg::round_sat(lane_res[i]);
			end
		end
	end

	assign pix_out.valid     = vld_s[LAT-1];
	assign pix_out.red_out   = out_q[0];
	assign pix_out.green_out = out_q[1];
	assign pix_out.blue_out  = out_q[2];

	`FTM_ASSERT_IMPL(a_ready_when_empty, !pix_out.valid, pix_in.ready, "input blocked with empty output")
	`FTM_ASSERT_NEXT(a_accept_enters, pix_in.valid && pix_in.ready, vld_s[0], "accepted transaction lost at entry")
	`FTM_ASSERT_NEXT(a_hold_on_stall, pix_out.valid && !pix_out.ready, pix_out.valid && $stable(pix_out.red_out) && $stable(pix_out.green_out) && $stable(pix_out.blue_out), "stalled result changed")

endmodule

// File: test/ftm_checker.sv
`timescale 1ns / 1ps
// Checker for the filmic tone-map block: watches both pixel channels,
// predicts each tone-mapped pixel and compares it. Depends on ftm_pkg, ftm_pix_if.
module ftm_checker #(
	parameter int IN_FRAC_BITS = ftm_pkg::IN_FRAC_DEF,
	parameter int OUT_FRAC_BITS = ftm_pkg::OUT_FRAC_DEF
) (
	input logic  clk,
	input logic  arst_n,
	ftm_in_if    pix_in,
	ftm_out_if   pix_out,
	output int   fail_count,
	output int   pending
);
	import ftm_pkg::*;

	typedef struct packed {
		chan_out_t red;
		chan_out_t green;
		chan_out_t blue;
	} pixel_out_t;

	pixel_out_t tone_queue[$];

	// Evaluate the scaled curve exactly and round half up, saturating
	function automatic chan_out_t tone_channel(input chan_in_t x);
		logic [127:0] xv, s, p, q, num, den, quo;
		xv = 128'(x);
		s = 128'd1 << IN_FRAC_BITS;
		p = xv * (128'd420 * xv + 128'd25 * s);
		q = 128'd30 * xv * xv + 128'd50 * xv * s + 128'd3 * s * s;
		num = (128'd6119 * p) << OUT_FRAC_BITS;
		den = 128'd66556 * q;
		quo = (2 * num + den) / (2 * den);
		if (quo > 128'd131071)
			return {OW{1'b1}};
		return quo[OW-1:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Predict on each input transaction, compare on each output transaction
	always @(posedge clk) begin
		pixel_out_t want;
		pixel_out_t nxt;
		if (arst_n) begin
			if (pix_in.valid && pix_in.ready) begin
				nxt = '{tone_channel(pix_in.red_in),
					tone_channel(pix_in.green_in), tone_channel(pix_in.blue_in)};
				tone_queue = {tone_queue, nxt};
			end
			if (pix_out.valid && pix_out.ready) begin
				if (tone_queue.size() == 0) begin
					report_mismatch("unexpected pixel", pix_out.red_out, -1);
				end else begin
					want = tone_queue.pop_front();
					if (pix_out.red_out !== want.red)
						report_mismatch("red", pix_out.red_out, want.red);
					if (pix_out.green_out !== want.green)
						report_mismatch("green", pix_out.green_out, want.green);
					if (pix_out.blue_out !== want.blue)
						report_mismatch("blue", pix_out.blue_out, want.blue);
				end
			end
		end
		pending = tone_queue.size();
	end
endmodule

// File: test/filmic_tonemap_pixel_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the filmic tone-map block: clock, reset, pixel stimulus
// with random idling and back-pressure, verdict. Depends on ftm_checker and the RTL.
module filmic_tonemap_pixel_top_tb;
	import ftm_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent_cnt;
	bit   calm;

	ftm_in_if  pix_in ();
	ftm_out_if pix_out ();

	filmic_tonemap_pixel_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in.sink),
		.pix_out (pix_out.source)
	);

	ftm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.pix_out    (pix_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("Test completed with failures");
		$finish;
	end

	// Draw a channel value: small, mid-range, near full scale or full range, equally likely
	function automatic chan_in_t rand_chan();
		case ($urandom_range(0, 3))
			0: return chan_in_t'($urandom_range(0, 255));
			1: return chan_in_t'($urandom_range(0, 24'h0FFFFF));
			2: return 24'hFFFFFF - chan_in_t'($urandom_range(0, 15));
			default: return chan_in_t'($urandom);
		endcase
	endfunction

	// Offer one pixel and hold it until the transaction completes
	task automatic send_pixel(input chan_in_t r, input chan_in_t g, input chan_in_t b);
		while (!calm && $urandom_range(0, 99) < 6) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.red_in <= r;
		pix_in.green_in <= g;
		pix_in.blue_in <= b;
		do @(posedge clk); while (!pix_in.ready);
		sent_cnt++;
		@(negedge clk);
	endtask

	// Receiver: random idling, one long hold-off mid run
	initial begin
		bit held;
		held = 0;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent_cnt >= 400) begin
				held = 1;
				pix_out.ready <= 1'b0;
				repeat (200) @(negedge clk);
			end
			pix_out.ready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	initial begin
		chan_in_t v;
		sent_cnt = 0;
		calm = 0;
		arst_n = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.red_in = '0;
		pix_in.green_in = '0;
		pix_in.blue_in = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero, smallest step, one, white point, extremes, bit patterns
		send_pixel(24'h000000, 24'h000000, 24'h000000);
		send_pixel(24'h000001, 24'h000002, 24'h000003);
		send_pixel(24'h010000, 24'h008000, 24'h020000);
		send_pixel(24'h059998, 24'h05999A, 24'h0B3333);
		send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(24'hAAAAAA, 24'h555555, 24'hFFFFFF);
		send_pixel(24'h555555, 24'hAAAAAA, 24'h000000);
		send_pixel(24'hFFFFFF, 24'h000000, 24'h000001);
		for (int i = 0; i < 12; i++) begin
			v = chan_in_t'(1) << (2 * i);
			send_pixel(v, v << 1, ~v);
		end

		// Random pixels; a calm stretch, then a pause until drained
		for (int i = 0; i < 1150; i++) begin
			calm = (i >= 600 && i < 800);
			if (i == 900) begin
				pix_in.valid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			send_pixel(rand_chan(), rand_chan(), rand_chan());
		end
		calm = 0;
		pix_in.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
